>>> rtl/sacl_pkg.sv
// sacl_pkg: shared types and constants of the set-associative cache lru simulator
// no dependencies; imported by sacl_lookup, sacl_stats and set_assoc_cache_lru_sim
`default_nettype none

package sacl_pkg;

  localparam int CNT_W     = 32;
  localparam int AGE_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  // age 0 is most recently used, saturates at the top value
  localparam logic [AGE_W-1:0] AGE_MAX  = 3'd7;
  // reference age on a miss (fill or eviction), above every stored age, so all other valid ways age
  localparam logic [AGE_W:0]   AGE_FILL = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_res_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic evicted;
    logic last;
  } acc_evt_t;

endpackage

`default_nettype wire

>>> rtl/sacl_lookup.sv
// sacl_lookup: tag compare, free way / lru victim pick and age update of one set row
// depends on sacl_pkg
`default_nettype none

module sacl_lookup import sacl_pkg::*; #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32
) (
  input  logic [TAG_W-1:0]                   tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0]      nways,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]     tags_i,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]     ages_i,
  input  logic [MAX_WAYS-1:0]                vld_i,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]     tags_o,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]     ages_o,
  output logic [MAX_WAYS-1:0]                vld_o,
  output lookup_res_t                        res
);

  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic                hit_any;
  logic                free_any;
  logic [WAY_W-1:0]    hit_w;
  logic [WAY_W-1:0]    free_w;
  logic [WAY_W-1:0]    vic_w;
  logic [WAY_W-1:0]    sel_w;
  logic [AGE_W-1:0]    vic_age;
  logic [AGE_W:0]      old_age;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = WCNT_W'(i) < nways;
      match[i]  = in_use[i] && vld_i[i] && (tags_i[i] == tag);
      free[i]   = in_use[i] && !vld_i[i];
    end
  end

  assign hit_any  = |match;
  assign free_any = |free;

  // lowest matching way and lowest free way
  always_comb begin
    hit_w  = '0;
    free_w = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_w = WAY_W'(i);
      end
      if (free[i]) begin
        free_w = WAY_W'(i);
      end
    end
  end

  // oldest in-use way, lowest index on a tie
  always_comb begin
    vic_w   = '0;
    vic_age = ages_i[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (ages_i[i] > vic_age)) begin
        vic_w   = WAY_W'(i);
        vic_age = ages_i[i];
      end
    end
  end

  assign sel_w   = hit_any ? hit_w : (free_any ? free_w : vic_w);
  assign old_age = hit_any ? {1'b0, ages_i[hit_w]} : AGE_FILL;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      tags_o[i] = tags_i[i];
      ages_o[i] = ages_i[i];
      vld_o[i]  = vld_i[i];
      if (WAY_W'(i) == sel_w) begin
        ages_o[i] = '0;
        vld_o[i]  = 1'b1;
        if (!hit_any) begin
          tags_o[i] = tag;
        end
      end else if (in_use[i] && vld_i[i] && ({1'b0, ages_i[i]} < old_age) &&
                   (ages_i[i] != AGE_MAX)) begin
        ages_o[i] = ages_i[i] + 1'b1;
      end
    end
  end

  assign res.hit     = hit_any;
  assign res.evicted = !hit_any && !free_any;

endmodule

`default_nettype wire

>>> rtl/sacl_stats.sv
// sacl_stats: hit/miss/eviction counters and the result register
// depends on sacl_pkg
`default_nettype none

module sacl_stats import sacl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  acc_evt_t         evt,
  output logic             out_valid,
  output logic             out_hit,
  output logic             out_evicted,
  output logic             out_last,
  output logic [CNT_W-1:0] out_hit_total,
  output logic [CNT_W-1:0] out_miss_total,
  output logic [CNT_W-1:0] out_evict_total
);

  logic             valid_r;
  logic             hit_r;
  logic             evicted_r;
  logic             last_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] evict_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      valid_r <= evt.vld;
      if (evt.vld) begin
        if (evt.hit) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_r <= miss_cnt_r + 1'b1;
        end
        if (evt.evicted) begin
          evict_cnt_r <= evict_cnt_r + 1'b1;
        end
      end
    end
  end

  // flags need no reset, they are qualified by valid_r
  always_ff @(posedge clk) begin
    if (evt.vld) begin
      hit_r     <= evt.hit;
      evicted_r <= evt.evicted;
      last_r    <= evt.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_hit         = hit_r;
  assign out_evicted     = evicted_r;
  assign out_last        = last_r;
  assign out_hit_total   = hit_cnt_r;
  assign out_miss_total  = miss_cnt_r;
  assign out_evict_total = evict_cnt_r;

endmodule

`default_nettype wire

>>> rtl/set_assoc_cache_lru_sim.sv
// set_assoc_cache_lru_sim: set-associative cache directory with lru replacement, top level
// timing: row read registered at accept, lookup combinational, result registered in sacl_stats;
//   a modify gives its second (always hit) result in the cycle after the first
// busy while the lookup stage holds a command: the set row read-modify-write must finish
// reset: config to defaults, counters zero, per-set valid flops cleared at once, no sweep
// depends on sacl_pkg, sacl_lookup, sacl_stats
`default_nettype none

module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [31:0]          in_mem_address,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // result channel, one cycle strobe
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic                 out_last,
  output logic [CNT_W-1:0]     out_hit_total,
  output logic [CNT_W-1:0]     out_miss_total,
  output logic [CNT_W-1:0]     out_evict_total
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SB_W     = 4;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [2:0] set_bits_r;
  logic [3:0] offset_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= 3'd0;
      offset_bits_r <= 4'd0;
      ways_r        <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SET_BITS:    set_bits_r    <= cfg_wdata[2:0];
        REG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        REG_WAYS:        ways_r        <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective set bit count and way count, clamped to the built geometry
  logic [SB_W-1:0]   sb_eff;
  logic [WCNT_W-1:0] nways;

  assign sb_eff = (32'(set_bits_r) > 32'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                        : SB_W'(set_bits_r);

  always_comb begin
    if (ways_r == 4'd0) begin
      nways = WCNT_W'(1);
    end else if (32'(ways_r) > 32'(MAX_WAYS)) begin
      nways = WCNT_W'(MAX_WAYS);
    end else begin
      nways = WCNT_W'(ways_r);
    end
  end

  // ---------------------------------------------------------------------------
  // address split: offset, set index, tag
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] addr_w;
  logic [ADDR_BITS-1:0] blk_addr;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_BITS-1:0] tag_in;

  assign addr_w   = ADDR_BITS'(in_mem_address);
  assign blk_addr = addr_w >> offset_bits_r;
  assign set_in   = SET_W'(blk_addr & ~({ADDR_BITS{1'b1}} << sb_eff));
  assign tag_in   = blk_addr >> sb_eff;

  // ---------------------------------------------------------------------------
  // accept and lookup stage control
  // ---------------------------------------------------------------------------
  logic accept;
  logic lk_vld_r;    // row read done, lookup and write-back this cycle
  logic lk_mod_r;    // item is a modify, second beat follows
  logic sec_pend_r;  // second beat of a modify
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;

  assign accept = start && !busy;
  // the row written by the lookup stage must land before the next read
  assign busy   = lk_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_vld_r   <= 1'b0;
      sec_pend_r <= 1'b0;
    end else begin
      lk_vld_r   <= accept && (op_t'(in_op) != OP_NOP);
      sec_pend_r <= lk_vld_r && lk_mod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r    <= set_in;
      tag_r    <= tag_in;
      lk_mod_r <= (op_t'(in_op) == OP_MODIFY);
    end
  end

  // ---------------------------------------------------------------------------
  // set row storage: tags, ages and way valids per set, plus one row-valid flop
  // per set so that reset needs no clearing pass
  // ---------------------------------------------------------------------------
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]     age_mem [NUM_SETS];
  logic [MAX_WAYS-1:0]                vld_mem [NUM_SETS];
  logic [NUM_SETS-1:0]                row_vld_r;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_rd_r;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     ages_rd_r;
  logic [MAX_WAYS-1:0]                vld_rd_r;
  logic                               rowv_rd_r;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_wr;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     ages_wr;
  logic [MAX_WAYS-1:0]                vld_wr;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     ages_cur;
  logic [MAX_WAYS-1:0]                vld_cur;

  // registered read at accept, write-back in the lookup stage
  always_ff @(posedge clk) begin
    if (accept) begin
      tags_rd_r <= tag_mem[set_in];
      ages_rd_r <= age_mem[set_in];
      vld_rd_r  <= vld_mem[set_in];
    end
    if (lk_vld_r) begin
      tag_mem[set_r] <= tags_wr;
      age_mem[set_r] <= ages_wr;
      vld_mem[set_r] <= vld_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rowv_rd_r <= 1'b0;
    end else begin
      if (accept) begin
        rowv_rd_r <= row_vld_r[set_in];
      end
      if (lk_vld_r) begin
        row_vld_r[set_r] <= 1'b1;
      end
    end
  end

  // a row never written reads as all invalid, ages zero
  assign ages_cur = rowv_rd_r ? ages_rd_r : '0;
  assign vld_cur  = rowv_rd_r ? vld_rd_r  : '0;

  // ---------------------------------------------------------------------------
  // lookup of the read row
  // ---------------------------------------------------------------------------
  lookup_res_t lk_res;

  sacl_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (ADDR_BITS)
  ) u_lookup (
    .tag    (tag_r),
    .nways  (nways),
    .tags_i (tags_rd_r),
    .ages_i (ages_cur),
    .vld_i  (vld_cur),
    .tags_o (tags_wr),
    .ages_o (ages_wr),
    .vld_o  (vld_wr),
    .res    (lk_res)
  );

  // ---------------------------------------------------------------------------
  // result beats: the lookup beat, then for a modify a second beat that always
  // hits the line just touched (its age is already 0, so the row is unchanged)
  // ---------------------------------------------------------------------------
  acc_evt_t evt;

  always_comb begin
    evt.vld = lk_vld_r || sec_pend_r;
    if (lk_vld_r) begin
      evt.hit     = lk_res.hit;
      evt.evicted = lk_res.evicted;
      evt.last    = !lk_mod_r;
    end else begin
      evt.hit     = 1'b1;
      evt.evicted = 1'b0;
      evt.last    = 1'b1;
    end
  end

  sacl_stats u_stats (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_last        (out_last),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total),
    .out_evict_total (out_evict_total)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a second beat never overlaps a lookup
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(lk_vld_r && sec_pend_r))
    else $error("lookup and second beat overlap");

  // every result beat comes from the lookup stage or a pending second beat
  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(lk_vld_r || sec_pend_r))
    else $error("result beat without work");

  // the second beat of a modify is a final hit
  a_second_hit: assert property (@(posedge clk) disable iff (!rst_n)
    sec_pend_r |=> (out_valid && out_hit && out_last && !out_evicted))
    else $error("second beat of a modify is not a final hit");

  // hit total moves by exactly the hit flag of each beat
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid |->
      (out_hit_total == $past(out_hit_total) + 32'(out_hit)))
    else $error("hit total out of step");

endmodule

`default_nettype wire
